// ----- hdl/spp_pkg.sv -----
// ----------------------------------------------------------------------------
// spp_pkg
// shared types, constants and the sine table generator for the plasma block
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int ADDR_W     = 8;
  localparam int SINE_DEPTH = 1 << ADDR_W;
  localparam int SINE_W     = 6;
  localparam int AMPLITUDE  = 42;
  localparam int COLOR_W    = 7;
  localparam int ROT_W      = 8;
  localparam int COORD_W    = 8;

  localparam logic [7:0] INDEX_MASK      = 8'd127;
  localparam logic [7:0] PHASE_ONE_STEP  = 8'd3;
  localparam logic [7:0] PHASE_TWO_STEP  = 8'd2;
  localparam logic [7:0] PHASE_THREE_STEP = 8'd1;
  localparam logic [7:0] ROTATION_STEP   = 8'd1;

  typedef enum logic {
    CMD_FRAME = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e               command;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
  } cmd_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color_index;
    logic [ROT_W-1:0]   palette_rotation;
  } pix_t;

  // table write port shared by all sine copies during the fill sweep
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [SINE_W-1:0] data;
  } fill_t;

  // six sine samples of one pixel
  typedef struct packed {
    logic [SINE_W-1:0] col0;
    logic [SINE_W-1:0] col1;
    logic [SINE_W-1:0] row0;
    logic [SINE_W-1:0] row1;
    logic [SINE_W-1:0] diag0;
    logic [SINE_W-1:0] diag1;
  } sine_taps_t;

  // quarter wave of sin, Q1.16, rounded
  localparam logic [16:0] QUARTER_SINE [0:64] = '{
    17'd0,     17'd1608,  17'd3216,  17'd4821,  17'd6424,  17'd8022,  17'd9616,  17'd11204,
    17'd12785, 17'd14359, 17'd15924, 17'd17479, 17'd19024, 17'd20557, 17'd22078, 17'd23586,
    17'd25080, 17'd26558, 17'd28020, 17'd29466, 17'd30893, 17'd32303, 17'd33692, 17'd35062,
    17'd36410, 17'd37736, 17'd39040, 17'd40320, 17'd41576, 17'd42806, 17'd44011, 17'd45190,
    17'd46341, 17'd47464, 17'd48559, 17'd49624, 17'd50660, 17'd51665, 17'd52639, 17'd53581,
    17'd54491, 17'd55368, 17'd56212, 17'd57022, 17'd57798, 17'd58538, 17'd59244, 17'd59914,
    17'd60547, 17'd61145, 17'd61705, 17'd62228, 17'd62714, 17'd63162, 17'd63572, 17'd63944,
    17'd64277, 17'd64571, 17'd64827, 17'd65043, 17'd65220, 17'd65358, 17'd65457, 17'd65516,
    17'd65536
  };

  // round(amplitude/2 * (1 + sin(2 pi i / 256)))
  function automatic logic [SINE_W-1:0] sine_value(input logic [ADDR_W-1:0] idx);
    logic [1:0]  quad;
    logic [6:0]  k;
    logic [16:0] mag;
    logic [17:0] offset;
    logic [23:0] prod;
    quad   = idx[7:6];
    k      = {1'b0, idx[5:0]};
    mag    = quad[0] ? QUARTER_SINE[7'd64 - k] : QUARTER_SINE[k];
    offset = quad[1] ? (18'd65536 - {1'b0, mag}) : (18'd65536 + {1'b0, mag});
    prod   = 24'(AMPLITUDE) * {6'b0, offset} + 24'd65536;
    return prod[17 +: SINE_W];
  endfunction

endpackage

// ----- hdl/sine_plasma_pixel_generator_top.sv -----
// ----------------------------------------------------------------------------
// sine_plasma_pixel_generator_top
// plasma palette index generator, when not stalled, one pixel per clock
// ----------------------------------------------------------------------------
// After reset the block loads all 256 entries of its sine tables (cmd_ready
// stays low meanwhile), then takes one item per clock unless the read stage
// is stalled, frame or pixel mixed freely. A frame item advances the three
// phases and the palette rotation and gives no result; a pixel item gives
// one result through the registered sine table read and then the output
// register. The six sine reads of a pixel come from three copies of the
// table, each a dual read port memory, so the table ports set the one item
// per clock figure. Phases and rotation are sampled when the pixel is
// accepted, so later frame items never disturb pixels already in flight.
// The output register and the read stage let a new item in while a result
// still waits to be taken.
module sine_plasma_pixel_generator_top import spp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic pix_valid,
  input  logic pix_ready,
  output pix_t pix
);

  // frame state
  logic [7:0] phase_one, phase_two, phase_three, rotation_count;

  fill_t fill;
  logic  filled;

  // read stage
  logic             s1_valid, s1_valid_next;
  logic [ROT_W-1:0] s1_rot;
  sine_taps_t       taps;

  logic out_free;
  logic accept, read_en, frame_en, mix_load;

  // table addresses, all wrap modulo 256
  logic [7:0] x, y, d;
  logic [7:0] a_col0, a_col1, a_row0, a_row1, a_diag0, a_diag1;

  spp_fill u_fill (
    .clk  (clk),
    .rst  (rst),
    .fill (fill),
    .done (filled)
  );

  assign cmd_ready = filled && (!s1_valid || out_free);
  assign accept    = cmd_valid && cmd_ready;
  assign read_en   = accept && (cmd.command == CMD_PIXEL);
  assign frame_en  = accept && (cmd.command == CMD_FRAME);
  assign mix_load  = s1_valid && out_free;

  always_comb begin
    x = cmd.pos_x;
    y = cmd.pos_y;
    d = x + y;
    a_col0  = x + {x[6:0], 1'b0} + phase_one;
    a_col1  = {x[4:0], 3'b0} - x - phase_two;
    a_row0  = {y[6:0], 1'b0} + phase_two;
    a_row1  = {y[5:0], 2'b0} + y + phase_three;
    a_diag0 = {d[6:0], 1'b0} - phase_three;
    a_diag1 = d + phase_one;
  end

  // column term table
  spp_ram #(.WIDTH(SINE_W), .DEPTH(SINE_DEPTH)) u_ram_col (
    .clk     (clk),
    .we      (fill.we),
    .waddr   (fill.addr),
    .wdata   (fill.data),
    .re      (read_en),
    .raddr_a (a_col0),
    .raddr_b (a_col1),
    .rdata_a (taps.col0),
    .rdata_b (taps.col1)
  );

  // row term table
  spp_ram #(.WIDTH(SINE_W), .DEPTH(SINE_DEPTH)) u_ram_row (
    .clk     (clk),
    .we      (fill.we),
    .waddr   (fill.addr),
    .wdata   (fill.data),
    .re      (read_en),
    .raddr_a (a_row0),
    .raddr_b (a_row1),
    .rdata_a (taps.row0),
    .rdata_b (taps.row1)
  );

  // diagonal term table
  spp_ram #(.WIDTH(SINE_W), .DEPTH(SINE_DEPTH)) u_ram_diag (
    .clk     (clk),
    .we      (fill.we),
    .waddr   (fill.addr),
    .wdata   (fill.data),
    .re      (read_en),
    .raddr_a (a_diag0),
    .raddr_b (a_diag1),
    .rdata_a (taps.diag0),
    .rdata_b (taps.diag1)
  );

  // phases and rotation step on each frame item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_one      <= '0;
      phase_two      <= '0;
      phase_three    <= '0;
      rotation_count <= '0;
    end else if (frame_en) begin
      phase_one      <= phase_one + PHASE_ONE_STEP;
      phase_two      <= phase_two + PHASE_TWO_STEP;
      phase_three    <= phase_three + PHASE_THREE_STEP;
      rotation_count <= rotation_count + ROTATION_STEP;
    end
  end

  // read stage holds while the output register is full
  always_comb begin
    s1_valid_next = s1_valid;
    if (read_en) begin
      s1_valid_next = 1'b1;
    end else if (out_free) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (read_en) begin
      s1_rot <= rotation_count;
    end
  end

  spp_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .load      (mix_load),
    .taps      (taps),
    .rotation  (s1_rot),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .free      (out_free)
  );

  // no item before the tables are loaded
  a_no_accept_while_filling: assert property (@(posedge clk) disable iff (rst)
    accept |-> !fill.we)
    else $error("item accepted during table fill");

  // a stalled read stage blocks new items
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |-> !cmd_ready)
    else $error("input taken while read stage is stalled");

  // a pixel item always lands in the read stage
  a_pixel_reaches_s1: assert property (@(posedge clk) disable iff (rst)
    read_en |=> s1_valid)
    else $error("pixel item lost after table read");

  // a frame item never creates a result
  a_frame_no_result: assert property (@(posedge clk) disable iff (rst)
    (frame_en && !s1_valid) |=> !s1_valid)
    else $error("frame item produced a pixel");

endmodule

// ----- hdl/spp_ram.sv -----
// ----------------------------------------------------------------------------
// spp_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module spp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hdl/spp_fill.sv -----
// ----------------------------------------------------------------------------
// spp_fill
// sweeps the sine tables after reset, one entry a cycle
// ----------------------------------------------------------------------------
module spp_fill import spp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  output fill_t fill,
  output logic  done
);

  logic [ADDR_W:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (!count[ADDR_W]) begin
      count <= count + 1'b1;
    end
  end

  assign done      = count[ADDR_W];
  assign fill.we   = !count[ADDR_W];
  assign fill.addr = count[ADDR_W-1:0];
  assign fill.data = sine_value(count[ADDR_W-1:0]);

endmodule

// ----- hdl/spp_mix.sv -----
// ----------------------------------------------------------------------------
// spp_mix
// averages the sine pairs, sums the three terms and holds the result item
// ----------------------------------------------------------------------------
module spp_mix import spp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sine_taps_t       taps,
  input  logic [ROT_W-1:0] rotation,
  output logic             pix_valid,
  input  logic             pix_ready,
  output pix_t             pix,
  output logic             free
);

  logic [SINE_W:0] col_pair, row_pair, diag_pair;
  logic [7:0]      sum;
  logic            pix_valid_next;

  always_comb begin
    col_pair  = {1'b0, taps.col0}  + {1'b0, taps.col1};
    row_pair  = {1'b0, taps.row0}  + {1'b0, taps.row1};
    diag_pair = {1'b0, taps.diag0} + {1'b0, taps.diag1};
    sum = {2'b0, col_pair[SINE_W:1]} + {2'b0, row_pair[SINE_W:1]}
        + {2'b0, diag_pair[SINE_W:1]};
  end

  assign free = !pix_valid || pix_ready;

  always_comb begin
    pix_valid_next = pix_valid;
    if (load) begin
      pix_valid_next = 1'b1;
    end else if (pix_ready) begin
      pix_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      pix_valid <= pix_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix.color_index      <= COLOR_W'(sum & INDEX_MASK);
      pix.palette_rotation <= rotation;
    end
  end

endmodule
